// ===== hw/rtl/roab_pkg.sv =====
package roab_pkg;

	// Channel and arithmetic widths
	localparam int unsigned ChW  = 8;
	localparam int unsigned NumW = 24;
	localparam int unsigned DenW = 16;
	localparam int unsigned NumCh = 3;

	localparam logic [ChW-1:0] ChMax = 8'hFF;

	// One restoring division step: remainder after the step and the quotient bit
	typedef struct packed {
		logic [NumW-1:0] rem;
		logic            qbit;
	} div_step_t;

	function automatic div_step_t div_step(input logic [NumW-1:0] rem,
			input logic [DenW-1:0] den, input logic [2:0] bitpos);
		logic [NumW-1:0] dsh;
		div_step_t       r;
		dsh = {{(NumW-DenW){1'b0}}, den} << bitpos;
		if (rem >= dsh) begin
			r.rem  = rem - dsh;
			r.qbit = 1'b1;
		end else begin
			r.rem  = rem;
			r.qbit = 1'b0;
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/rgba_over_alpha_blender.sv =====
// Channel   Direction  Handshake        Fields
// command   in         start / busy     top_pixel[31:0], bottom_pixel[31:0]
// result    out        done (strobe)    blended_pixel[31:0]
//
// One pixel pair is taken every cycle; busy is always low.
// An accepted pair passes a multiply stage and a sum stage, then a four-stage
// restoring divider that resolves two quotient bits per stage, then the output
// register, which drives the result and done together.
// Reset clears the valid bits only; the pipeline never holds, so the receiver
// must take each result in the cycle it appears; the block does not enforce this.
module rgba_over_alpha_blender (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] top_pixel,
	input  logic [31:0] bottom_pixel,
	output logic        done,
	output logic [31:0] blended_pixel
);

	localparam int unsigned NumCh = roab_pkg::NumCh;

	logic accept;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, done_q;
	logic byp_s1, byp_s2, byp_s3, byp_s4, byp_s5, byp_s6;
	logic [31:0] bot_s1, bot_s2, bot_s3, bot_s4, bot_s5, bot_s6;
	logic [31:0] blended_q;

	logic [roab_pkg::ChW-1:0]    ta_s1, inv_s1;
	logic [15:0]                 bainv_s1;
	logic [15:0]                 pt_s1 [NumCh];
	logic [15:0]                 pb_s1 [NumCh];
	logic [roab_pkg::NumW-1:0]   num_s2 [NumCh];
	logic [roab_pkg::DenW-1:0]   den_s2;
	logic [roab_pkg::ChW-1:0]    quot [NumCh];

	logic [roab_pkg::ChW-1:0]    ta_in, ba_in, inv_in;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	assign ta_in  = top_pixel[7:0];
	assign ba_in  = bottom_pixel[7:0];
	assign inv_in = roab_pkg::ChMax - ta_in;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= accept;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			done_q <= v_s6;
		end
	end

	// Stage 1: alpha weights and per-channel alpha products
	always_ff @(posedge clk) begin
		ta_s1    <= ta_in;
		inv_s1   <= inv_in;
		bainv_s1 <= ba_in * inv_in;
		byp_s1   <= (ta_in == 8'd0);
		bot_s1   <= bottom_pixel;
		for (int c = 0; c < NumCh; c++) begin
			pt_s1[c] <= top_pixel[8*(c+1) +: 8] * ta_in;
			pb_s1[c] <= bottom_pixel[8*(c+1) +: 8] * ba_in;
		end
	end

	// Stage 2: numerators and the shared divisor
	always_ff @(posedge clk) begin
		den_s2 <= {ta_s1, 8'd0} - {8'd0, ta_s1} + bainv_s1;
		byp_s2 <= byp_s1;
		bot_s2 <= bot_s1;
		for (int c = 0; c < NumCh; c++) begin
			num_s2[c] <= ({pt_s1[c], 8'd0} - {8'd0, pt_s1[c]})
				+ ({8'd0, pb_s1[c]} * {16'd0, inv_s1});
		end
	end

	// Carry bypass flag and bottom word alongside the divider
	always_ff @(posedge clk) begin
		byp_s3 <= byp_s2;
		bot_s3 <= bot_s2;
		byp_s4 <= byp_s3;
		bot_s4 <= bot_s3;
		byp_s5 <= byp_s4;
		bot_s5 <= bot_s4;
		byp_s6 <= byp_s5;
		bot_s6 <= bot_s5;
	end

	// Stages 3 to 6: one divider per colour
	for (genvar c = 0; c < NumCh; c++) begin : g_div
		roab_div u_div (
			.clk  (clk),
			.num  (num_s2[c]),
			.den  (den_s2),
			.quot (quot[c])
		);
	end

	// Form the output word; pass bottom through when top alpha is zero
	always_ff @(posedge clk) begin
		if (byp_s6) begin
			blended_q <= bot_s6;
		end else begin
			blended_q <= {quot[2], quot[1], quot[0], roab_pkg::ChMax};
		end
	end

	assign done          = done_q;
	assign blended_pixel = blended_q;

	// Every result traces back to an accepted input word
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 7))
		else $error("result without matching input word");

	// Transparent top leaves the bottom word untouched
	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(top_pixel[7:0], 7) == 8'd0)
			|-> blended_pixel == $past(bottom_pixel, 7))
		else $error("bottom word not passed through");

	// Blended words carry opaque alpha
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(top_pixel[7:0], 7) != 8'd0)
			|-> blended_pixel[7:0] == 8'hFF)
		else $error("blended alpha not opaque");

endmodule

// ===== hw/rtl/roab_div.sv =====
module roab_div (
	input  logic                        clk,
	input  logic [roab_pkg::NumW-1:0]   num,
	input  logic [roab_pkg::DenW-1:0]   den,
	output logic [roab_pkg::ChW-1:0]    quot
);

	logic [roab_pkg::NumW-1:0] rem_s3, rem_s4, rem_s5;
	logic [roab_pkg::DenW-1:0] den_s3, den_s4, den_s5;
	logic [roab_pkg::ChW-1:0]  q_s3, q_s4, q_s5, q_s6;

	roab_pkg::div_step_t a3, b3, a4, b4, a5, b5, a6, b6;

	// Resolve two quotient bits per stage, high bits first
	always_comb begin
		a3 = roab_pkg::div_step(num, den, 3'd7);
		b3 = roab_pkg::div_step(a3.rem, den, 3'd6);
		a4 = roab_pkg::div_step(rem_s3, den_s3, 3'd5);
		b4 = roab_pkg::div_step(a4.rem, den_s3, 3'd4);
		a5 = roab_pkg::div_step(rem_s4, den_s4, 3'd3);
		b5 = roab_pkg::div_step(a5.rem, den_s4, 3'd2);
		a6 = roab_pkg::div_step(rem_s5, den_s5, 3'd1);
		b6 = roab_pkg::div_step(a6.rem, den_s5, 3'd0);
	end

	// Advance remainder, divisor and partial quotient
	always_ff @(posedge clk) begin
		rem_s3 <= b3.rem;
		den_s3 <= den;
		q_s3   <= {a3.qbit, b3.qbit, 6'b0};
		rem_s4 <= b4.rem;
		den_s4 <= den_s3;
		q_s4   <= {q_s3[7:6], a4.qbit, b4.qbit, 4'b0};
		rem_s5 <= b5.rem;
		den_s5 <= den_s4;
		q_s5   <= {q_s4[7:4], a5.qbit, b5.qbit, 2'b0};
		q_s6   <= {q_s5[7:2], a6.qbit, b6.qbit};
	end

	assign quot = q_s6;

endmodule
